>>> hdl/aesbme_pkg.sv
// ----------------------------------------------------------------------------
// aesbme_pkg
// Shared types, register and mode codes, S-box tables and AES round helpers.
// ----------------------------------------------------------------------------
package aesbme_pkg;

  localparam logic [2:0] REG_KEY_HIGH   = 3'd0;
  localparam logic [2:0] REG_KEY_LOW    = 3'd1;
  localparam logic [2:0] REG_IV_HIGH    = 3'd2;
  localparam logic [2:0] REG_IV_LOW     = 3'd3;
  localparam logic [2:0] REG_MODE       = 3'd4;
  localparam logic [2:0] REG_WORD_ORDER = 3'd5;
  localparam logic [2:0] REG_BYTE_SWAP  = 3'd6;
  localparam logic [2:0] REG_COUNT      = 3'd7;

  localparam logic [2:0] MODE_PASS    = 3'd0;
  localparam logic [2:0] MODE_CTR     = 3'd1;
  localparam logic [2:0] MODE_CBC_DEC = 3'd2;
  localparam logic [2:0] MODE_CBC_ENC = 3'd3;
  localparam logic [2:0] MODE_ECB_DEC = 3'd4;
  localparam logic [2:0] MODE_ECB_ENC = 3'd5;

  localparam logic [3:0] LAST_ROUND = 4'd10;

  typedef struct packed {
    logic [31:0] in_word_0;
    logic [31:0] in_word_1;
    logic [31:0] in_word_2;
    logic [31:0] in_word_3;
    logic        begin_run;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_word_0;
    logic [31:0] out_word_1;
    logic [31:0] out_word_2;
    logic [31:0] out_word_3;
    logic        last_block;
  } out_beat_t;

  // round key RAM write port, one 128-bit row per round
  typedef struct packed {
    logic         en;
    logic [3:0]   row;
    logic [127:0] data;
  } rk_wr_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // multiply by a small constant in GF(2^8)
  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] c);
    logic [7:0] a2, a4, a8;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    return (c[0] ? a : 8'h00) ^ (c[1] ? a2 : 8'h00) ^ (c[2] ? a4 : 8'h00) ^
           (c[3] ? a8 : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    if (inv) begin
      return {gm(a0,4'he) ^ gm(a1,4'hb) ^ gm(a2,4'hd) ^ gm(a3,4'h9),
              gm(a0,4'h9) ^ gm(a1,4'he) ^ gm(a2,4'hb) ^ gm(a3,4'hd),
              gm(a0,4'hd) ^ gm(a1,4'h9) ^ gm(a2,4'he) ^ gm(a3,4'hb),
              gm(a0,4'hb) ^ gm(a1,4'hd) ^ gm(a2,4'h9) ^ gm(a3,4'he)};
    end
    return {gm(a0,4'h2) ^ gm(a1,4'h3) ^ a2 ^ a3,
            a0 ^ gm(a1,4'h2) ^ gm(a2,4'h3) ^ a3,
            a0 ^ a1 ^ gm(a2,4'h2) ^ gm(a3,4'h3),
            gm(a0,4'h3) ^ a1 ^ a2 ^ gm(a3,4'h2)};
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // one round without the key add; column 0 in the top word, row 0 in the top byte
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic inv,
                                             input logic last);
    logic [127:0] t;
    logic [7:0]   b;
    int           from;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int q = 0; q < 4; q++) begin
        from = inv ? ((c + 4 - q) & 3) : ((c + q) & 3);
        b = s[127 - 32*from - 8*q -: 8];
        t[127 - 32*c - 8*q -: 8] = inv ? INV_SBOX[b] : SBOX[b];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 32*c -: 32] = mix_col(t[127 - 32*c -: 32], inv);
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // port word order <-> cipher column order; the mapping is its own inverse
  function automatic logic [127:0] word_perm(input logic [127:0] v, input logic rev,
                                             input logic swap);
    logic [31:0] w0, w1, w2, w3;
    w0 = swap ? bswap(v[127:96]) : v[127:96];
    w1 = swap ? bswap(v[95:64])  : v[95:64];
    w2 = swap ? bswap(v[63:32])  : v[63:32];
    w3 = swap ? bswap(v[31:0])   : v[31:0];
    return rev ? {w0, w1, w2, w3} : {w3, w2, w1, w0};
  endfunction

endpackage

>>> hdl/aesbme_key_expand.sv
// ----------------------------------------------------------------------------
// aesbme_key_expand
// Expands the cipher key one round key per cycle into the round key RAM rows.
// ----------------------------------------------------------------------------
module aesbme_key_expand (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  inv,
  input  logic [127:0]          key,
  output aesbme_pkg::rk_wr_t    wr,
  output logic                  done
);

  logic         busy;
  logic         inv_q;
  logic [3:0]   idx;
  logic [7:0]   rcon;
  logic [127:0] cur;
  logic [127:0] cur_next;
  logic [31:0]  tw;
  logic [127:0] row_data;

  always_comb begin
    tw = aesbme_pkg::sub_word({cur[23:0], cur[31:24]}) ^ {rcon, 24'h0};
    cur_next[127:96] = cur[127:96] ^ tw;
    cur_next[95:64]  = cur[95:64]  ^ cur_next[127:96];
    cur_next[63:32]  = cur[63:32]  ^ cur_next[95:64];
    cur_next[31:0]   = cur[31:0]   ^ cur_next[63:32];
    row_data = cur;
    // equivalent inverse cipher: inner round keys go through InvMixColumns
    if (inv_q && idx != 4'd0 && idx != aesbme_pkg::LAST_ROUND) begin
      for (int c = 0; c < 4; c++) begin
        row_data[127 - 32*c -: 32] = aesbme_pkg::mix_col(cur[127 - 32*c -: 32], 1'b1);
      end
    end
  end

  assign wr.en   = busy;
  assign wr.row  = inv_q ? (aesbme_pkg::LAST_ROUND - idx) : idx;
  assign wr.data = row_data;
  assign done    = busy && idx == aesbme_pkg::LAST_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      idx   <= '0;
      inv_q <= inv;
      cur   <= key;
      rcon  <= 8'h01;
    end else if (busy) begin
      cur  <= cur_next;
      rcon <= aesbme_pkg::xt(rcon);
      idx  <= idx + 4'd1;
      if (idx == aesbme_pkg::LAST_ROUND) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/aes128_block_mode_engine.sv
// ----------------------------------------------------------------------------
// aes128_block_mode_engine
// AES-128 ECB/CBC/CTR/pass-through block engine over a round key RAM.
// ----------------------------------------------------------------------------
// One block is taken at a time. A cipher block passes from accept to result
// through a load step, the initial key add, ten rounds and then the result
// register; pass-through goes from the load straight to the result register.
// A beat with begin_run first expands the key into the 11-row round key RAM,
// one row per cycle. The round loop is bound by the one RAM read per round.
// The next block is taken once the result has been handed to the output
// register, which may still be held by out_stall.
module aes128_block_mode_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  aesbme_pkg::in_beat_t   in_beat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output aesbme_pkg::out_beat_t  out_beat
);

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_START, S_KEY0, S_ROUND, S_FIN} state_t;

  state_t       state;
  logic [127:0] key;
  logic [127:0] iv;
  logic [2:0]   mode;
  logic         rev;
  logic         swap;
  logic [15:0]  block_count;

  logic [127:0] xblk;
  logic [127:0] chain;
  logic [127:0] st;
  logic [15:0]  blocks_left;
  logic [3:0]   rnd;
  logic         dec;
  logic         ciph;

  logic [127:0] rk_mem [11];
  logic [127:0] rk_q;
  logic [3:0]   rd_row;

  aesbme_pkg::rk_wr_t rk_wr;
  logic               exp_done;
  logic               accept;
  logic               exp_start;
  logic [127:0]       y;
  logic [15:0]        left_next;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state != S_IDLE;
  assign exp_start = accept && in_beat.begin_run;
  assign dec       = mode == aesbme_pkg::MODE_CBC_DEC || mode == aesbme_pkg::MODE_ECB_DEC;
  assign ciph      = mode == aesbme_pkg::MODE_CTR || mode == aesbme_pkg::MODE_CBC_DEC ||
                     mode == aesbme_pkg::MODE_CBC_ENC || dec ||
                     mode == aesbme_pkg::MODE_ECB_ENC;
  assign left_next = blocks_left - 16'd1;

  aesbme_key_expand u_kexp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .inv   (dec),
    .key   (key),
    .wr    (rk_wr),
    .done  (exp_done)
  );

  always_ff @(posedge clk) begin
    if (rk_wr.en) begin
      rk_mem[rk_wr.row] <= rk_wr.data;
    end
    rk_q <= rk_mem[rd_row];
  end

  always_comb begin
    unique case (state)
      S_START: rd_row = 4'd0;
      S_KEY0:  rd_row = 4'd1;
      S_ROUND: rd_row = (rnd == aesbme_pkg::LAST_ROUND) ? 4'd0 : rnd + 4'd1;
      default: rd_row = 4'd0;
    endcase
  end

  always_comb begin
    y = st;
    unique case (mode)
      aesbme_pkg::MODE_CTR:     y = st ^ xblk;
      aesbme_pkg::MODE_CBC_DEC: y = st ^ chain;
      default:                  y = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      iv          <= '0;
      mode        <= aesbme_pkg::MODE_PASS;
      rev         <= 1'b0;
      swap        <= 1'b0;
      block_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aesbme_pkg::REG_KEY_HIGH:   key[127:64] <= cfg_data;
        aesbme_pkg::REG_KEY_LOW:    key[63:0]   <= cfg_data;
        aesbme_pkg::REG_IV_HIGH:    iv[127:64]  <= cfg_data;
        aesbme_pkg::REG_IV_LOW:     iv[63:0]    <= cfg_data;
        aesbme_pkg::REG_MODE:       mode        <= cfg_data[2:0];
        aesbme_pkg::REG_WORD_ORDER: rev         <= cfg_data[0];
        aesbme_pkg::REG_BYTE_SWAP:  swap        <= cfg_data[0];
        aesbme_pkg::REG_COUNT:      block_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      chain       <= '0;
      blocks_left <= '0;
      rnd         <= '0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            xblk <= aesbme_pkg::word_perm({in_beat.in_word_0, in_beat.in_word_1,
                                           in_beat.in_word_2, in_beat.in_word_3}, rev, swap);
            if (in_beat.begin_run) begin
              blocks_left <= block_count;
              chain       <= iv;
              state       <= S_EXPAND;
            end else begin
              state <= S_START;
            end
          end
        end
        S_EXPAND: begin
          if (exp_done) begin
            state <= S_START;
          end
        end
        S_START: begin
          if (mode == aesbme_pkg::MODE_CTR) begin
            st <= chain;
          end else if (mode == aesbme_pkg::MODE_CBC_ENC) begin
            st <= xblk ^ chain;
          end else begin
            st <= xblk;
          end
          state <= ciph ? S_KEY0 : S_FIN;
        end
        S_KEY0: begin
          st    <= st ^ rk_q;
          rnd   <= 4'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          st  <= aesbme_pkg::aes_round(st, dec, rnd == aesbme_pkg::LAST_ROUND) ^ rk_q;
          rnd <= rnd + 4'd1;
          if (rnd == aesbme_pkg::LAST_ROUND) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            {out_beat.out_word_0, out_beat.out_word_1, out_beat.out_word_2,
             out_beat.out_word_3} <= aesbme_pkg::word_perm(y, rev, swap);
            out_beat.last_block <= left_next == 16'd0;
            out_valid           <= 1'b1;
            blocks_left         <= left_next;
            if (mode == aesbme_pkg::MODE_CTR) begin
              chain <= chain + 128'd1;
            end else if (mode == aesbme_pkg::MODE_CBC_DEC) begin
              chain <= xblk;
            end else if (mode == aesbme_pkg::MODE_CBC_ENC) begin
              chain <= st;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rk_write_in_expand: assert property (@(posedge clk) disable iff (rst)
    rk_wr.en |-> state == S_EXPAND)
    else $error("round key write outside expansion");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> (rnd >= 4'd1 && rnd <= aesbme_pkg::LAST_ROUND))
    else $error("round counter out of range");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || !out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("finished block not delivered");

  a_expand_done_only_expanding: assert property (@(posedge clk) disable iff (rst)
    exp_done |-> state == S_EXPAND)
    else $error("key expansion finished outside expand state");

endmodule
